### rtl/sasc_pkg.sv
// Shared types, codes and helpers for the set-associative LRU cache model.
package sasc_pkg;

    localparam int CNT_W      = 32;
    localparam int CFG_SET_W  = 3;
    localparam int CFG_BLK_W  = 5;
    localparam int CFG_WAY_W  = 4;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

    // Request types.
    localparam logic [1:0] REQ_IFETCH = 2'd0;
    localparam logic [1:0] REQ_LOAD   = 2'd1;
    localparam logic [1:0] REQ_STORE  = 2'd2;
    localparam logic [1:0] REQ_MODIFY = 2'd3;

    // Outcome codes of the first access.
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;
    localparam logic [1:0] OUT_NONE  = 2'd3;

    // Classification of one lookup, exactly one bit set.
    typedef struct packed {
        logic hit;
        logic fill;
        logic evict;
    } sasc_access_t;

    // Adds zero, one or two to a total and sticks at all ones.
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [1:0] inc);
        logic [CNT_W:0] sum;
        sum = {1'b0, a} + {{(CNT_W-1){1'b0}}, inc};
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

endpackage

### rtl/sasc_set_mem.sv
// One-port-write, one-port-read set memory with a registered read.
module sasc_set_mem #(
    parameter int IDX_W = 6,
    parameter int ROW_W = 272
) (
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [ROW_W-1:0] wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output logic [ROW_W-1:0] rdata
);

    logic [ROW_W-1:0] mem [2**IDX_W];
    logic [ROW_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/sasc_lru_update.sv
// Tag compare, victim choice and recency update for one set row.
module sasc_lru_update #(
    parameter int WAYS  = 8,
    parameter int TAG_W = 30,
    parameter int REC_W = 3,
    parameter int NW    = 4
) (
    input  logic [WAYS*(1+TAG_W+REC_W)-1:0] row_in,
    input  logic [TAG_W-1:0]                tag,
    input  logic [NW-1:0]                   n_eff,
    output logic [WAYS*(1+TAG_W+REC_W)-1:0] row_out,
    output sasc_pkg::sasc_access_t          access
);
    import sasc_pkg::*;

    localparam int LINE_W = 1 + TAG_W + REC_W;
    localparam int WI_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [REC_W-1:0] REC_MAX = REC_W'(WAYS - 1);

    logic [WAYS-1:0]  valid;
    logic [WAYS-1:0]  in_use;
    logic [TAG_W-1:0] tags [WAYS];
    logic [REC_W-1:0] rec  [WAYS];
    logic             hit_found;
    logic             free_found;
    logic [WI_W-1:0]  hit_way;
    logic [WI_W-1:0]  free_way;
    logic [WI_W-1:0]  victim;
    logic [REC_W-1:0] oldest;
    logic [WI_W-1:0]  sel_way;
    logic [REC_W-1:0] old_rank;
    logic             age_all;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            valid[w]  = row_in[w*LINE_W + LINE_W - 1];
            tags[w]   = row_in[w*LINE_W + REC_W +: TAG_W];
            rec[w]    = row_in[w*LINE_W +: REC_W];
            in_use[w] = (w < int'(n_eff));
        end
    end

    // Lowest-numbered matching way and lowest-numbered empty way.
    always_comb
    begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (in_use[w] && valid[w] && (tags[w] == tag))
            begin
                hit_found = 1'b1;
                hit_way   = WI_W'(w);
            end
            if (in_use[w] && !valid[w])
            begin
                free_found = 1'b1;
                free_way   = WI_W'(w);
            end
        end
    end

    // Oldest way; ties go to the lowest number.
    always_comb
    begin
        oldest = rec[0];
        victim = '0;
        for (int w = 1; w < WAYS; w++)
        begin
            if (in_use[w] && (rec[w] > oldest))
            begin
                oldest = rec[w];
                victim = WI_W'(w);
            end
        end
    end

    always_comb
    begin
        access.hit   = hit_found;
        access.fill  = !hit_found && free_found;
        access.evict = !hit_found && !free_found;
        if (hit_found)
        begin
            sel_way  = hit_way;
            old_rank = rec[hit_way];
            age_all  = 1'b0;
        end
        else if (free_found)
        begin
            sel_way  = free_way;
            old_rank = '0;
            age_all  = 1'b1;
        end
        else
        begin
            sel_way  = victim;
            old_rank = oldest;
            age_all  = 1'b0;
        end
    end

    always_comb
    begin
        row_out = row_in;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WI_W'(w) == sel_way)
            begin
                row_out[w*LINE_W + LINE_W - 1]  = 1'b1;
                row_out[w*LINE_W + REC_W +: TAG_W] = tag;
                row_out[w*LINE_W +: REC_W]     = '0;
            end
            else if (in_use[w] && valid[w] && (age_all || (rec[w] < old_rank))
                     && (rec[w] < REC_MAX))
            begin
                row_out[w*LINE_W +: REC_W] = rec[w] + REC_W'(1);
            end
        end
    end

endmodule

### rtl/set_assoc_lru_cache_sim.sv
// Top level of the set-associative LRU cache hit, miss and eviction model.
//
//  Channel   Signals                                   Direction
//  -------   ---------------------------------------   ---------
//  request   in_valid, in_ready, req_type, address     in
//  result    out_valid, out_ready, outcome, second_hit,
//            hit_total, miss_total, eviction_total     out
//  config    cfg_we, cfg_index, cfg_wdata              in
//
// In each request transaction, the accept cycle reads the set row from the set
// memory, and the next cycle compares tags, updates recency and writes the
// row back. A modify's second access always hits, so it costs no extra memory
// pass. Reset clears the per-set valid flags at once, so no clearing pass is
// needed. A waiting result blocks the next request: a request is taken while
// the result register is full only if that result leaves in the same cycle.
module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = 6,
    parameter int WAYS         = 8,
    parameter int ADDR_WIDTH   = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      req_type,
    input  logic [ADDR_WIDTH-1:0]           address,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      outcome,
    output logic                            second_hit,
    output logic [sasc_pkg::CNT_W-1:0]      hit_total,
    output logic [sasc_pkg::CNT_W-1:0]      miss_total,
    output logic [sasc_pkg::CNT_W-1:0]      eviction_total,
    input  logic                            cfg_we,
    input  logic [sasc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sasc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import sasc_pkg::*;

    localparam int IDX_W    = MAX_SET_BITS;
    localparam int NUM_SETS = 2 ** MAX_SET_BITS;
    localparam int TAG_W    = ADDR_WIDTH - 2;
    localparam int REC_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW       = $clog2(WAYS + 1);
    localparam int LINE_W   = 1 + TAG_W + REC_W;
    localparam int ROW_W    = WAYS * LINE_W;
    localparam int SH_W     = 6;

    typedef enum logic {ST_IDLE, ST_LOOKUP} state_t;

    state_t                state_reg;
    logic                  out_valid_reg;
    logic [1:0]            outcome_reg;
    logic                  second_reg;
    logic [CNT_W-1:0]      hits_reg;
    logic [CNT_W-1:0]      misses_reg;
    logic [CNT_W-1:0]      evictions_reg;
    logic [NUM_SETS-1:0]   row_valid_reg;

    logic [CFG_SET_W-1:0]  set_bits_reg;
    logic [CFG_BLK_W-1:0]  block_bits_reg;
    logic [CFG_WAY_W-1:0]  ways_reg;

    logic [1:0]            kind_reg;
    logic [IDX_W-1:0]      set_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [NW-1:0]         n_reg;
    logic                  row_hot_reg;

    logic                  accept;
    logic [CFG_SET_W-1:0]  s_eff;
    logic [CFG_BLK_W-1:0]  b_eff;
    logic [NW-1:0]         n_eff;
    logic [ADDR_WIDTH-1:0] set_shifted;
    logic [ADDR_WIDTH-1:0] tag_shifted;
    logic [IDX_W-1:0]      set_idx;
    logic [SH_W-1:0]       tag_sh;

    logic                  mem_we;
    logic [ROW_W-1:0]      mem_rdata;
    logic [ROW_W-1:0]      row_in;
    logic [ROW_W-1:0]      row_out;
    sasc_access_t          access;
    logic                  active;
    logic                  modify;
    logic [1:0]            hit_inc;
    logic [CNT_W-1:0]      hits_next;
    logic [CNT_W-1:0]      misses_next;
    logic [CNT_W-1:0]      evictions_next;
    logic [1:0]            outcome_next;

    // Configuration registers; values are clamped where a request is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= CFG_SET_W'(1);
            block_bits_reg <= CFG_BLK_W'(1);
            ways_reg       <= CFG_WAY_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SET_BITS:    set_bits_reg   <= cfg_wdata[CFG_SET_W-1:0];
                REG_BLOCK_BITS:  block_bits_reg <= cfg_wdata[CFG_BLK_W-1:0];
                REG_WAYS_IN_USE: ways_reg       <= cfg_wdata[CFG_WAY_W-1:0];
                default:         ;
            endcase
        end
    end

    // Address split: the set index sits above the block offset, the tag above it.
    always_comb
    begin
        if (set_bits_reg == '0)
            s_eff = CFG_SET_W'(1);
        else if (int'(set_bits_reg) > MAX_SET_BITS)
            s_eff = CFG_SET_W'(MAX_SET_BITS);
        else
            s_eff = set_bits_reg;

        b_eff = (block_bits_reg == '0) ? CFG_BLK_W'(1) : block_bits_reg;

        if (ways_reg == '0)
            n_eff = NW'(1);
        else if (int'(ways_reg) > WAYS)
            n_eff = NW'(WAYS);
        else
            n_eff = NW'(ways_reg);

        set_shifted = address >> b_eff;
        set_idx     = set_shifted[IDX_W-1:0] & ~({IDX_W{1'b1}} << s_eff);
        tag_sh      = SH_W'(b_eff) + SH_W'(s_eff);
        tag_shifted = address >> tag_sh;
    end

    // A result still waiting is fine if it leaves in this same cycle.
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // Request fields held for the lookup cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= req_type;
            set_reg     <= set_idx;
            tag_reg     <= tag_shifted[TAG_W-1:0];
            n_reg       <= n_eff;
            row_hot_reg <= row_valid_reg[set_idx];
        end
    end

    sasc_set_mem #(
        .IDX_W (IDX_W),
        .ROW_W (ROW_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (set_reg),
        .wdata (row_out),
        .re    (accept),
        .raddr (set_idx),
        .rdata (mem_rdata)
    );

    // A set never written since reset reads as all ways empty with rank zero.
    assign row_in = row_hot_reg ? mem_rdata : '0;

    sasc_lru_update #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W),
        .REC_W (REC_W),
        .NW    (NW)
    ) u_update (
        .row_in  (row_in),
        .tag     (tag_reg),
        .n_eff   (n_reg),
        .row_out (row_out),
        .access  (access)
    );

    // An instruction fetch makes no access. A modify's second access finds
    // the line just placed at rank zero, so it hits and leaves the row as is.
    always_comb
    begin
        active  = (kind_reg != REQ_IFETCH);
        modify  = (kind_reg == REQ_MODIFY);
        mem_we  = (state_reg == ST_LOOKUP) && active;
        hit_inc = 2'(active && access.hit) + 2'(modify);

        hits_next      = sat_add(hits_reg, hit_inc);
        misses_next    = sat_add(misses_reg, 2'(active && !access.hit));
        evictions_next = sat_add(evictions_reg, 2'(active && access.evict));

        if (!active)
            outcome_next = OUT_NONE;
        else if (access.hit)
            outcome_next = OUT_HIT;
        else if (access.fill)
            outcome_next = OUT_FILL;
        else
            outcome_next = OUT_EVICT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            outcome_reg   <= OUT_NONE;
            second_reg    <= 1'b0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evictions_reg <= '0;
            row_valid_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP:
                begin
                    state_reg     <= ST_IDLE;
                    out_valid_reg <= 1'b1;
                    outcome_reg   <= outcome_next;
                    second_reg    <= modify;
                    hits_reg      <= hits_next;
                    misses_reg    <= misses_next;
                    evictions_reg <= evictions_next;
                    if (mem_we)
                    begin
                        row_valid_reg[set_reg] <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The totals change only when a new result is loaded, so they can be
    // shown straight from the counters.
    assign out_valid      = out_valid_reg;
    assign outcome        = outcome_reg;
    assign second_hit     = second_reg;
    assign hit_total      = hits_reg;
    assign miss_total     = misses_reg;
    assign eviction_total = evictions_reg;

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_LOOKUP))
        else $error("accepted transaction did not start a lookup");

    a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_LOOKUP))
        else $error("result appeared without a lookup");

    a_write_in_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_LOOKUP) && (kind_reg != REQ_IFETCH))
        else $error("set memory written outside a lookup");

    a_hits_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (hits_reg >= $past(hits_reg)) && (misses_reg >= $past(misses_reg)))
        else $error("running total decreased");

    a_second_needs_access: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && second_reg) |-> (outcome_reg != OUT_NONE))
        else $error("second hit reported without an access");

endmodule

### bench/tb_set_assoc_lru_cache_sim.sv
// Self-checking testbench for the set-associative LRU cache hit, miss and eviction model.
`timescale 1ns / 100ps

module tb_set_assoc_lru_cache_sim;

    import sasc_pkg::*;

    localparam int SET_BITS_MAX = 6;
    localparam int WAY_COUNT    = 8;
    localparam int ADDR_W       = 32;
    localparam int LINE_COUNT   = (1 << SET_BITS_MAX) * WAY_COUNT;

    // The receiver hold-off is the longest quiet stretch of a correct run. The
    // watchdog limit is many times that, so only a hung block can reach it.
    localparam int RX_HOLD_CYCLES = 250;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
    } cache_request_t;

    typedef struct {
        logic [1:0]       outcome;
        logic             second_hit;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] evictions;
    } access_report_t;

    // Every input of the block starts at a known value.
    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [1:0]            req_type  = REQ_IFETCH;
    logic [ADDR_W-1:0]     address   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            outcome;
    logic                  second_hit;
    logic [CNT_W-1:0]      hit_total;
    logic [CNT_W-1:0]      miss_total;
    logic [CNT_W-1:0]      eviction_total;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_SET_BITS;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Requests waiting for the driver, and the reports that the cache model
    // predicts for requests the block has already taken, oldest first.
    cache_request_t request_backlog[$];
    access_report_t predicted_reports[$];

    int          mismatch_count = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_token     = 0;
    int          hold_seen      = 0;
    int          hold_left      = 0;
    int          idle_cycles    = 0;

    // Cache model state: per-line valid flag, tag and recency rank (0 is the
    // most recently used), the three running totals and the register copies.
    bit                 way_valid [LINE_COUNT];
    logic [63:0]        way_tag   [LINE_COUNT];
    bit [2:0]           way_rank  [LINE_COUNT];
    logic [CNT_W-1:0]   model_hits   = '0;
    logic [CNT_W-1:0]   model_misses = '0;
    logic [CNT_W-1:0]   evict_count  = '0;
    logic [CFG_SET_W-1:0] geo_set_bits   = CFG_SET_W'(1);
    logic [CFG_BLK_W-1:0] geo_block_bits = CFG_BLK_W'(1);
    logic [CFG_WAY_W-1:0] geo_ways       = CFG_WAY_W'(1);

    // Register settings of the random phases: set bits, block bits, ways.
    // They include the top and bottom of each range and values outside it,
    // which the block must clamp (block bits above 25 are used as given).
    int phase_geometry[10][3] = '{
        '{3, 5, 4}, '{6, 2, 8}, '{0, 0, 0}, '{7, 31, 15}, '{1, 25, 2},
        '{4, 3, 3}, '{2, 1, 9}, '{5, 12, 6}, '{6, 26, 8}, '{3, 4, 5}
    };

    set_assoc_lru_cache_sim #(
        .MAX_SET_BITS (SET_BITS_MAX),
        .WAYS         (WAY_COUNT),
        .ADDR_WIDTH   (ADDR_W)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .address        (address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .outcome        (outcome),
        .second_hit     (second_hit),
        .hit_total      (hit_total),
        .miss_total     (miss_total),
        .eviction_total (eviction_total),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Totals stick at all ones instead of wrapping.
    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] x);
        return (x == '1) ? x : x + 1'b1;
    endfunction

    // Register values as the block uses them: zero counts as one, and set
    // bits and ways are capped at the sizes the block was built with.
    function automatic void clamp_geometry(output int s, output int b, output int n);
        s = geo_set_bits;
        b = geo_block_bits;
        n = geo_ways;
        if (s < 1) s = 1;
        if (s > SET_BITS_MAX) s = SET_BITS_MAX;
        if (b < 1) b = 1;
        if (n < 1) n = 1;
        if (n > WAY_COUNT) n = WAY_COUNT;
    endfunction

    // Makes way w the most recent one. Valid ways that were younger than it
    // grow one step older, and a rank never goes past the oldest possible.
    function automatic void promote(int base, int n, int w, int old_rank);
        for (int v = 0; v < n; v++)
        begin
            if (v != w && way_valid[base + v] && way_rank[base + v] < old_rank
                && way_rank[base + v] < WAY_COUNT - 1)
                way_rank[base + v] = way_rank[base + v] + 1'b1;
        end
        way_rank[base + w] = '0;
    endfunction

    // One lookup: a hit, a fill of the first empty way, or an eviction of the
    // oldest way, where the lowest-numbered way wins a tie.
    function automatic logic [1:0] cache_lookup(logic [ADDR_W-1:0] addr);
        int          s, b, n, base, victim, oldest;
        logic [63:0] set_idx, tag;
        clamp_geometry(s, b, n);
        set_idx = (64'(addr) >> b) & ((64'd1 << s) - 1);
        tag     = 64'(addr) >> (b + s);
        base    = int'(set_idx) * WAY_COUNT;
        for (int w = 0; w < n; w++)
        begin
            if (way_valid[base + w] && way_tag[base + w] == tag)
            begin
                promote(base, n, w, way_rank[base + w]);
                model_hits = bump(model_hits);
                return OUT_HIT;
            end
        end
        model_misses = bump(model_misses);
        for (int w = 0; w < n; w++)
        begin
            if (!way_valid[base + w])
            begin
                promote(base, n, w, 255);
                way_valid[base + w] = 1'b1;
                way_tag[base + w]   = tag;
                return OUT_FILL;
            end
        end
        evict_count = bump(evict_count);
        victim = 0;
        oldest = way_rank[base];
        for (int w = 1; w < n; w++)
        begin
            if (way_rank[base + w] > oldest)
            begin
                oldest = way_rank[base + w];
                victim = w;
            end
        end
        promote(base, n, victim, oldest);
        way_tag[base + victim] = tag;
        return OUT_EVICT;
    endfunction

    // Works out the report of one request. A fetch touches nothing, and a
    // modify is two lookups of the same address.
    function automatic access_report_t tally_request(logic [1:0] kind,
                                                     logic [ADDR_W-1:0] addr);
        access_report_t rep;
        rep.outcome    = OUT_NONE;
        rep.second_hit = 1'b0;
        if (kind != REQ_IFETCH)
        begin
            rep.outcome = cache_lookup(addr);
            if (kind == REQ_MODIFY)
                rep.second_hit = (cache_lookup(addr) == OUT_HIT);
        end
        rep.hits      = model_hits;
        rep.misses    = model_misses;
        rep.evictions = evict_count;
        return rep;
    endfunction

    function automatic void check_field(string what, logic [CNT_W-1:0] want,
                                        logic [CNT_W-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    // Queue pushes happen at the falling edge, away from the driver's pops.
    task automatic queue_request(logic [1:0] kind, logic [ADDR_W-1:0] addr);
        cache_request_t req;
        req.kind = kind;
        req.addr = addr;
        request_backlog.push_back(req);
    endtask

    // Writes one register at a rising edge and keeps the model's copy in step.
    // It is only called while the block is idle, so no request sees the change
    // half way. It returns at a falling edge.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_SET_BITS:    geo_set_bits   = val[CFG_SET_W-1:0];
            REG_BLOCK_BITS:  geo_block_bits = val[CFG_BLK_W-1:0];
            REG_WAYS_IN_USE: geo_ways       = val[CFG_WAY_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Waits until every queued request is taken and every predicted report has
    // come back, then lets the pipeline settle. The watchdog ends the run if
    // the block never gets there.
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (request_backlog.size() != 0 || in_valid || predicted_reports.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Request driver. A transaction is taken at an edge where valid and ready
    // are both high, and the model predicts its report right there, from the
    // payload that was on the port. A new request goes out only once the slot
    // is free, so valid and the payload hold steady while the block stalls.
    always @(posedge clk)
    begin : request_driver
        cache_request_t next_req;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predicted_reports.push_back(tally_request(req_type, address));
            if (!in_valid || in_ready)
            begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = request_backlog.pop_front();
                    in_valid <= 1'b1;
                    req_type <= next_req.kind;
                    address  <= next_req.addr;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor. Each result transaction is checked field by field
    // against the oldest prediction. Ready stalls at random, and when the
    // stimulus raises the hold token the monitor keeps ready low for a long
    // stretch, counted here, so that the block fills up and refuses requests.
    always @(posedge clk)
    begin : result_monitor
        access_report_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_reports.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result transaction with nothing predicted, outcome %0d",
                             $time, outcome);
                end
                else
                begin
                    want = predicted_reports.pop_front();
                    check_field("outcome", CNT_W'(want.outcome), CNT_W'(outcome));
                    check_field("second_hit", CNT_W'(want.second_hit), CNT_W'(second_hit));
                    check_field("hit_total", want.hits, hit_total);
                    check_field("miss_total", want.misses, miss_total);
                    check_field("eviction_total", want.evictions, eviction_total);
                end
            end
            if (hold_token != hold_seen)
            begin
                hold_seen <= hold_token;
                hold_left <= RX_HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: counts cycles in which neither channel moves a transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int             s, b, n, p, k, half, mode;
        int unsigned    pick, tag_base, set_sel;
        logic [1:0]     kind;
        logic [63:0]    line, addr64;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests at the reset settings: two sets, one way, two-byte
        // blocks. This covers a fetch, a fill, a hit on another byte of the
        // same block, the all-ones address, a modify that evicts and then hits,
        // a modify that hits twice, and an eviction by a load.
        queue_request(REQ_IFETCH, 32'h0000_0000);
        queue_request(REQ_LOAD,   32'h0000_0000);
        queue_request(REQ_LOAD,   32'h0000_0001);
        queue_request(REQ_STORE,  32'hFFFF_FFFF);
        queue_request(REQ_MODIFY, 32'h0000_0004);
        queue_request(REQ_MODIFY, 32'h0000_0004);
        queue_request(REQ_LOAD,   32'h0000_0000);
        queue_request(REQ_IFETCH, 32'hFFFF_FFFF);
        wait_for_drain();

        // Four sets, 16-byte blocks, three ways. Lines stored under the old
        // settings stay as they are. Tags t in set 0 sit at address t << 6,
        // so this walks the LRU order through fills, hits and evictions.
        write_reg(REG_SET_BITS, 5'd2);
        write_reg(REG_BLOCK_BITS, 5'd4);
        write_reg(REG_WAYS_IN_USE, 5'd3);
        queue_request(REQ_LOAD,   32'd0 << 6);
        queue_request(REQ_LOAD,   32'd1 << 6);
        queue_request(REQ_LOAD,   32'd2 << 6);
        queue_request(REQ_STORE,  32'd0 << 6);
        queue_request(REQ_STORE,  32'd3 << 6);
        queue_request(REQ_MODIFY, 32'd1 << 6);
        queue_request(REQ_LOAD,   32'd4 << 6);
        queue_request(REQ_LOAD,   32'hFFFF_FFC0);
        wait_for_drain();

        // Shrink to one way, then grow to four: the ways that sat unused
        // come back with the ranks they had, which sets up ties on eviction.
        write_reg(REG_WAYS_IN_USE, 5'd1);
        queue_request(REQ_LOAD, 32'd5 << 6);
        wait_for_drain();
        write_reg(REG_WAYS_IN_USE, 5'd4);
        queue_request(REQ_LOAD,   32'd6 << 6);
        queue_request(REQ_STORE,  32'd7 << 6);
        queue_request(REQ_MODIFY, 32'd8 << 6);
        wait_for_drain();

        // Random phases. Each one writes all three registers, picks an idle
        // pattern, and sends two batches with a full drain in between, so the
        // sender also pauses until every report is back. Most requests hit a
        // few sets with a small pool of tags near a random base, so fills,
        // hits and evictions all happen; the rest are fully random noise.
        for (p = 0; p < 10; p++)
        begin
            write_reg(REG_SET_BITS,    CFG_DATA_W'(phase_geometry[p][0]));
            write_reg(REG_BLOCK_BITS,  CFG_DATA_W'(phase_geometry[p][1]));
            write_reg(REG_WAYS_IN_USE, CFG_DATA_W'(phase_geometry[p][2]));
            mode           = p % 4;
            send_idle_pct  = (mode == 1) ? 65 : (mode == 3) ? 29 : 0;
            recv_stall_pct = (mode == 2) ? 65 : (mode == 3) ? 29 : 0;
            tag_base       = $urandom();
            clamp_geometry(s, b, n);
            for (half = 0; half < 2; half++)
            begin
                // In the first phase the sender never idles, so a long
                // receiver hold-off backs the block up against its input.
                if (p == 0 && half == 0)
                    hold_token++;
                for (k = 0; k < 19; k++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 15)
                        queue_request(2'($urandom_range(3)), $urandom());
                    else
                    begin
                        pick = $urandom_range(99);
                        kind = (pick < 8)  ? REQ_IFETCH :
                               (pick < 43) ? REQ_LOAD   :
                               (pick < 68) ? REQ_STORE  : REQ_MODIFY;
                        set_sel = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(3);
                        line    = 64'(tag_base + $urandom_range(n + 1));
                        addr64  = (line << (b + s))
                                | ((64'(set_sel) & ((64'd1 << s) - 1)) << b)
                                | (64'($urandom()) & ((64'd1 << b) - 1));
                        queue_request(kind, addr64[ADDR_W-1:0]);
                    end
                end
                wait_for_drain();
            end
        end

        // Give a stray late result time to show up before the verdict.
        repeat (20) @(negedge clk);
        if (predicted_reports.size() != 0)
        begin
            mismatch_count += predicted_reports.size();
            $display("%0t: %0d predicted results never arrived",
                     $time, predicted_reports.size());
        end
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### set_assoc_lru_cache_sim.f
rtl/sasc_pkg.sv
rtl/sasc_set_mem.sv
rtl/sasc_lru_update.sv
rtl/set_assoc_lru_cache_sim.sv
bench/tb_set_assoc_lru_cache_sim.sv
